/* rtl/core/swlq_pkg.sv */
// shared types and codes for the sorted weight list queue
package swlq_pkg;

    localparam int SYM_W       = 8;
    localparam int WT_W        = 32;
    localparam int POS_W       = 8;
    localparam int OCC_W       = 9;
    localparam int DEPTH_DFLT  = 256;

    // requested action of one input word
    typedef enum logic [1:0] {
        ACT_PUSH   = 2'd0,
        ACT_ORDER  = 2'd1,
        ACT_REMOVE = 2'd2,
        ACT_SEARCH = 2'd3
    } t_action;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    // per-cell data movement
    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2
    } t_op;

    // control broadcast to every cell of the row
    typedef struct packed {
        t_action            mode;
        logic               hit_en;
        t_op                op;
        logic [SYM_W-1:0]   key_sym;
        logic [WT_W-1:0]    key_wt;
    } t_cell_ctl;

endpackage

/* rtl/core/swlq_cell.sv */
// one list slot: holds an entry, compares it to the key, shifts with its neighbors
module swlq_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 9
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  swlq_pkg::t_cell_ctl       i_ctl,
    input  logic [CNT_W-1:0]          i_count,
    input  logic                      i_shift,
    input  logic                      i_first,
    input  logic [swlq_pkg::SYM_W-1:0] i_left_sym,
    input  logic [swlq_pkg::WT_W-1:0]  i_left_wt,
    input  logic [swlq_pkg::SYM_W-1:0] i_right_sym,
    input  logic [swlq_pkg::WT_W-1:0]  i_right_wt,
    output logic [swlq_pkg::SYM_W-1:0] o_sym,
    output logic [swlq_pkg::WT_W-1:0]  o_wt,
    output logic                      o_hit
);
    import swlq_pkg::*;

    logic [SYM_W-1:0] r_sym;
    logic [WT_W-1:0]  r_wt;
    logic             r_hit;
    logic             n_hit;
    logic             occ;

    // slot holds a live entry when it lies below the count
    assign occ = (i_count > CNT_W'(IDX));

    // key compare for the requested action
    always_comb begin
        case (i_ctl.mode)
            ACT_PUSH:   n_hit = 1'b1;
            ACT_ORDER:  n_hit = !occ || (r_wt >= i_ctl.key_wt);
            ACT_SEARCH: n_hit = occ && (r_sym == i_ctl.key_sym);
            default:    n_hit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else if (i_ctl.hit_en) begin
            r_hit <= n_hit;
        end
    end

    // entry storage: take the new entry, the left neighbor or the right neighbor
    always_ff @(posedge i_clk) begin
        case (i_ctl.op)
            OP_INSERT: begin
                if (i_first) begin
                    r_sym <= i_ctl.key_sym;
                    r_wt  <= i_ctl.key_wt;
                end else if (i_shift) begin
                    r_sym <= i_left_sym;
                    r_wt  <= i_left_wt;
                end
            end
            OP_REMOVE: begin
                r_sym <= i_right_sym;
                r_wt  <= i_right_wt;
            end
            default: ;
        endcase
    end

    assign o_sym = r_sym;
    assign o_wt  = r_wt;
    assign o_hit = r_hit;

endmodule

/* rtl/core/swlq_find.sv */
// locates the first hit in the cell row: shift mask, one-hot position and its index
module swlq_find #(
    parameter int DEPTH = swlq_pkg::DEPTH_DFLT,
    parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [DEPTH-1:0]   i_hit,
    output logic [DEPTH-1:0]   o_shift,
    output logic [DEPTH-1:0]   o_first,
    output logic               o_any,
    output logic [IDX_W-1:0]   o_pos
);
    import swlq_pkg::*;

    logic [DEPTH-1:0] pre;
    logic [DEPTH-1:0] r_shift;
    logic [DEPTH-1:0] r_first;
    logic [IDX_W-1:0] pos;

    // log-depth prefix or toward the tail
    always_comb begin
        pre = i_hit;
        for (int s = 1; s < DEPTH; s = s * 2) begin
            pre = pre | (pre << s);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_shift <= pre;
            r_first <= pre & ~(pre << 1);
        end
    end

    // index of the one-hot first position
    always_comb begin
        pos = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (r_first[i]) begin
                pos = pos | IDX_W'(i);
            end
        end
    end

    assign o_shift = r_shift;
    assign o_first = r_first;
    assign o_any   = r_shift[DEPTH-1];
    assign o_pos   = pos;

endmodule

/* rtl/core/sorted_weight_list_queue.sv */
// sorted weight list queue: top level with sequencer, cell row and first-hit locator
// each word runs through the steps compare in the cells, locate, shift and report;
// a new word is taken only once the sequencer is back in idle, and
// the output register lets the next word be taken while a result waits
// reset clears the entry count, the sequencer and the output valid; slot contents
// are left as they are and are never read before being written
module sorted_weight_list_queue #(
    parameter int LIST_DEPTH = swlq_pkg::DEPTH_DFLT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [1:0]                    i_action,
    input  logic [swlq_pkg::SYM_W-1:0]    i_key_symbol,
    input  logic [swlq_pkg::WT_W-1:0]     i_entry_weight,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [1:0]                    o_status,
    output logic [swlq_pkg::POS_W-1:0]    o_found_position,
    output logic [swlq_pkg::SYM_W-1:0]    o_head_symbol,
    output logic [swlq_pkg::WT_W-1:0]     o_head_weight,
    output logic [swlq_pkg::OCC_W-1:0]    o_occupancy
);
    import swlq_pkg::*;

    localparam int CNT_W = $clog2(LIST_DEPTH + 1);
    localparam int IDX_W = $clog2(LIST_DEPTH);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_HIT   = 5'b00010,
        S_FIND  = 5'b00100,
        S_APPLY = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state             r_state, n_state;
    t_action            r_action;
    logic [SYM_W-1:0]   r_key_sym;
    logic [WT_W-1:0]    r_key_wt;
    logic [CNT_W-1:0]   r_count;
    t_status            r_status;
    logic [POS_W-1:0]   r_pos;
    logic               r_out_valid;
    t_status            r_out_status;
    logic [POS_W-1:0]   r_out_pos;
    logic [SYM_W-1:0]   r_out_sym;
    logic [WT_W-1:0]    r_out_wt;
    logic [OCC_W-1:0]   r_out_occ;

    t_cell_ctl          ctl;
    logic               full;
    logic               empty;
    logic               is_insert;
    logic               out_free;
    logic [LIST_DEPTH-1:0] hit;
    logic [LIST_DEPTH-1:0] shift;
    logic [LIST_DEPTH-1:0] first;
    logic               any;
    logic [IDX_W-1:0]   pos;
    logic [31:0]        pos_ext;
    logic [31:0]        occ_ext;
    logic [SYM_W-1:0]   cell_sym [LIST_DEPTH];
    logic [WT_W-1:0]    cell_wt  [LIST_DEPTH];

    assign full      = (r_count == CNT_W'(LIST_DEPTH));
    assign empty     = (r_count == '0);
    assign is_insert = (r_action == ACT_PUSH) || (r_action == ACT_ORDER);
    assign out_free  = !r_out_valid || i_ready;
    assign pos_ext   = 32'(pos);
    assign occ_ext   = 32'(r_count);

    // control broadcast to the cell row
    always_comb begin
        ctl.mode    = r_action;
        ctl.hit_en  = (r_state == S_HIT);
        ctl.key_sym = r_key_sym;
        ctl.key_wt  = r_key_wt;
        ctl.op      = OP_HOLD;
        if (r_state == S_APPLY) begin
            if (is_insert && !full) begin
                ctl.op = OP_INSERT;
            end else if ((r_action == ACT_REMOVE) && !empty) begin
                ctl.op = OP_REMOVE;
            end
        end
    end

    // cell row, each slot wired to its neighbors
    for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
        logic [SYM_W-1:0] l_sym, r_sym_nb;
        logic [WT_W-1:0]  l_wt, r_wt_nb;
        if (g == 0) begin : g_head
            assign l_sym = r_key_sym;
            assign l_wt  = r_key_wt;
        end else begin : g_body
            assign l_sym = cell_sym[g-1];
            assign l_wt  = cell_wt[g-1];
        end
        if (g == LIST_DEPTH - 1) begin : g_tail
            assign r_sym_nb = cell_sym[g];
            assign r_wt_nb  = cell_wt[g];
        end else begin : g_mid
            assign r_sym_nb = cell_sym[g+1];
            assign r_wt_nb  = cell_wt[g+1];
        end
        swlq_cell #(
            .IDX   (g),
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (ctl),
            .i_count     (r_count),
            .i_shift     (shift[g]),
            .i_first     (first[g]),
            .i_left_sym  (l_sym),
            .i_left_wt   (l_wt),
            .i_right_sym (r_sym_nb),
            .i_right_wt  (r_wt_nb),
            .o_sym       (cell_sym[g]),
            .o_wt        (cell_wt[g]),
            .o_hit       (hit[g])
        );
    end

    // first-hit locator
    swlq_find #(
        .DEPTH (LIST_DEPTH),
        .IDX_W (IDX_W)
    ) u_find (
        .i_clk   (i_clk),
        .i_en    (r_state == S_FIND),
        .i_hit   (hit),
        .o_shift (shift),
        .o_first (first),
        .o_any   (any),
        .o_pos   (pos)
    );

    // sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_valid) n_state = S_HIT;
            S_HIT:   n_state = S_FIND;
            S_FIND:  n_state = S_APPLY;
            S_APPLY: n_state = S_DONE;
            S_DONE:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // capture the input word
    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && i_valid) begin
            r_action  <= t_action'(i_action);
            r_key_sym <= i_key_symbol;
            r_key_wt  <= i_entry_weight;
        end
    end

    // entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (ctl.op == OP_INSERT) begin
            r_count <= r_count + 1'b1;
        end else if (ctl.op == OP_REMOVE) begin
            r_count <= r_count - 1'b1;
        end
    end

    // status and search position
    always_ff @(posedge i_clk) begin
        if (r_state == S_APPLY) begin
            r_pos <= '0;
            case (r_action)
                ACT_PUSH, ACT_ORDER: r_status <= full ? ST_FULL : ST_OK;
                ACT_REMOVE:          r_status <= empty ? ST_EMPTY : ST_OK;
                ACT_SEARCH: begin
                    r_status <= any ? ST_OK : ST_NOTFOUND;
                    if (any) begin
                        r_pos <= pos_ext[POS_W-1:0];
                    end
                end
                default:             r_status <= ST_OK;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_DONE) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && out_free) begin
            r_out_status <= r_status;
            r_out_pos    <= r_pos;
            r_out_sym    <= empty ? '0 : cell_sym[0];
            r_out_wt     <= empty ? '0 : cell_wt[0];
            r_out_occ    <= occ_ext[OCC_W-1:0];
        end
    end

    assign o_ready          = (r_state == S_IDLE);
    assign o_valid          = r_out_valid;
    assign o_status         = r_out_status;
    assign o_found_position = r_out_pos;
    assign o_head_symbol    = r_out_sym;
    assign o_head_weight    = r_out_wt;
    assign o_occupancy      = r_out_occ;

endmodule

/* rtl/core/swlq_checker.sv */
// port-level checks for the sorted weight list queue, bound to the top level
module swlq_checker #(
    parameter int LIST_DEPTH = swlq_pkg::DEPTH_DFLT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic                          o_ready,
    input  logic [1:0]                    i_action,
    input  logic [swlq_pkg::SYM_W-1:0]    i_key_symbol,
    input  logic [swlq_pkg::WT_W-1:0]     i_entry_weight,
    input  logic                          o_valid,
    input  logic                          i_ready,
    input  logic [1:0]                    o_status,
    input  logic [swlq_pkg::POS_W-1:0]    o_found_position,
    input  logic [swlq_pkg::SYM_W-1:0]    o_head_symbol,
    input  logic [swlq_pkg::WT_W-1:0]     o_head_weight,
    input  logic [swlq_pkg::OCC_W-1:0]    o_occupancy
);
    import swlq_pkg::*;

    localparam logic [31:0] DEPTH_EXT = 32'(LIST_DEPTH);

    // a waiting result stays up
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result dropped before it was taken");

    // a refused insert only happens on a full list
    a_full_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_FULL) |-> o_occupancy == DEPTH_EXT[OCC_W-1:0])
        else $error("full status with room left");

    // an empty status leaves an empty list with a cleared head
    a_empty_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_EMPTY) |->
            (o_occupancy == '0) && (o_head_symbol == '0) && (o_head_weight == '0))
        else $error("empty status with entries or a head");

    // a position is reported only on a successful search
    a_pos_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != ST_OK) |-> o_found_position == '0)
        else $error("position reported without a match");

    // occupancy never passes the list depth
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (LIST_DEPTH < 512) |-> 32'(o_occupancy) <= DEPTH_EXT)
        else $error("occupancy beyond list depth");

endmodule

bind sorted_weight_list_queue swlq_checker #(.LIST_DEPTH(LIST_DEPTH)) u_swlq_checker (.*);
